FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/itoa_pkg.sv
// Types, codes and character constants of the padded integer-to-ASCII formatter.
package itoa_pkg;

    localparam int unsigned BIN_W           = 32;
    localparam int unsigned NUM_DIGITS      = 10;
    localparam int unsigned DIG_BITS        = 4 * NUM_DIGITS;
    localparam int unsigned MAX_FIELD_WIDTH = 31;

    localparam logic [1:0] KIND_SDEC      = 2'd0;
    localparam logic [1:0] KIND_UDEC      = 2'd1;
    localparam logic [1:0] KIND_HEX_LOWER = 2'd2;
    localparam logic [1:0] KIND_HEX_UPPER = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] DEC_BASE = 8'd10;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CONV,
        S_NORM,
        S_PREP,
        S_LEAD,
        S_LPAD,
        S_SIGN,
        S_DIGIT,
        S_RPAD
    } t_state;

    // Add three to every BCD digit of five or more before the next shift.
    function automatic logic [DIG_BITS-1:0] bcd_adjust(input logic [DIG_BITS-1:0] x);
        logic [DIG_BITS-1:0] y;
        logic [3:0]          nib;
        y = x;
        for (int i = 0; i < int'(NUM_DIGITS); i++) begin
            nib = x[4*i +: 4];
            if (nib >= 4'd5) begin
                y[4*i +: 4] = nib + 4'd3;
            end
        end
        return y;
    endfunction

endpackage

FILE: hw/rtl/itoa_req_if.sv
// Request channel carrying one number and its formatting controls.
interface itoa_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic [1:0]  kind;
    logic [4:0]  field_width;
    logic        left_align;
    logic        zero_fill;

    modport source (output valid, value, kind, field_width, left_align, zero_fill,
                    input ready);
    modport sink   (input valid, value, kind, field_width, left_align, zero_fill,
                    output ready);
endinterface

FILE: hw/rtl/itoa_chr_if.sv
// Character channel carrying one ASCII code and the end-of-number mark.
interface itoa_chr_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, char_code, last, input ready);
    modport sink   (input valid, char_code, last, output ready);
endinterface

FILE: hw/rtl/integer_to_ascii_padded_core.sv
// Top level of the padded integer-to-ASCII formatter.
// Decimal requests pass through the bit-serial double-dabble converter, hex requests skip it;
// then leading zero digits are stripped and the padding is sized.
// The first character is registered after that; the further characters are then emitted as
// the output takes them, and a request holds the block until its last character is emitted.
// Synchronous active-low reset returns the sequencer to idle and empties the output register.
module integer_to_ascii_padded_core
    import itoa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    itoa_req_if.sink          i_req,
    itoa_chr_if.source        o_chr
);

    t_state                r_state, n_state;
    logic [BIN_W-1:0]      r_bin;
    logic [DIG_BITS-1:0]   r_dig;
    logic [4:0]            r_bit_cnt;
    logic [3:0]            r_nd;
    logic [4:0]            r_w;
    logic [4:0]            r_pad_cnt;
    logic                  r_neg, r_upper, r_right, r_zero, r_sign;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out_char;
    logic                  r_out_last;

    logic                  req_acc;
    logic                  req_neg;
    logic                  req_hex;
    logic [4:0]            w_in;
    logic [DIG_BITS-1:0]   dig_adj;
    logic                  norm_shift;
    logic                  room;
    logic                  emit;
    logic [7:0]            emit_char;
    logic                  emit_last;
    logic [3:0]            top_dig;
    logic [7:0]            pad_char;
    logic                  lead;
    logic                  sign_mid;
    logic [4:0]            w_eff;
    logic [4:0]            text_len;
    logic [4:0]            padn;

    assign i_req.ready     = (r_state == S_IDLE);
    assign req_acc         = i_req.valid && i_req.ready;
    assign req_neg         = (i_req.kind == KIND_SDEC) && i_req.value[BIN_W-1];
    assign req_hex         = (i_req.kind == KIND_HEX_LOWER) || (i_req.kind == KIND_HEX_UPPER);
    assign w_in            = (32'(i_req.field_width) > MAX_FIELD_WIDTH)
                             ? 5'(MAX_FIELD_WIDTH) : i_req.field_width;

    assign o_chr.valid     = r_out_valid;
    assign o_chr.char_code = r_out_char;
    assign o_chr.last      = r_out_last;

    assign dig_adj    = bcd_adjust(r_dig);
    assign top_dig    = r_dig[DIG_BITS-1 -: 4];
    assign norm_shift = (r_nd > 4'd1) && (top_dig == 4'd0);
    assign pad_char   = r_zero ? CH_ZERO : CH_SPACE;
    assign room       = !r_out_valid || o_chr.ready;

    // With zero padding and a width, the minus leads and takes one place of the width.
    assign lead     = r_neg && (r_w != 5'd0) && r_zero;
    assign sign_mid = r_neg && !lead;
    assign w_eff    = r_w - {4'd0, lead};
    assign text_len = {1'b0, r_nd} + {4'd0, sign_mid};
    assign padn     = (w_eff > text_len) ? (w_eff - text_len) : 5'd0;

    // Character selection for each emission state.
    always_comb begin
        emit      = 1'b0;
        emit_char = CH_SPACE;
        emit_last = 1'b0;
        case (r_state)
            S_LEAD: begin
                emit      = room;
                emit_char = CH_MINUS;
            end
            S_LPAD: begin
                emit      = room;
                emit_char = pad_char;
            end
            S_SIGN: begin
                emit      = room;
                emit_char = CH_MINUS;
            end
            S_DIGIT: begin
                emit      = room;
                if (top_dig < 4'd10) begin
                    emit_char = CH_ZERO + {4'd0, top_dig};
                end else begin
                    emit_char = (r_upper ? CH_UA : CH_LA) + {4'd0, top_dig} - DEC_BASE;
                end
                emit_last = (r_nd == 4'd1) && (!r_right || r_pad_cnt == 5'd0);
            end
            S_RPAD: begin
                emit      = room;
                emit_char = pad_char;
                emit_last = (r_pad_cnt == 5'd1);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_chr.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_state = req_hex ? S_NORM : S_CONV;
                end
            end
            S_CONV: begin
                if (r_bit_cnt == 5'(BIN_W - 1)) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (!norm_shift) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (lead) begin
                    n_state = S_LEAD;
                end else if (!r_right && padn != 5'd0) begin
                    n_state = S_LPAD;
                end else if (sign_mid) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_DIGIT;
                end
            end
            S_LEAD: begin
                if (emit) begin
                    n_state = (!r_right && r_pad_cnt != 5'd0) ? S_LPAD : S_DIGIT;
                end
            end
            S_LPAD: begin
                if (emit && r_pad_cnt == 5'd1) begin
                    n_state = r_sign ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                if (emit) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (emit && r_nd == 4'd1) begin
                    n_state = (r_right && r_pad_cnt != 5'd0) ? S_RPAD : S_IDLE;
                end
            end
            S_RPAD: begin
                if (emit && r_pad_cnt == 5'd1) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    r_bin     <= req_neg ? (~i_req.value + 32'd1) : i_req.value;
                    r_neg     <= req_neg;
                    r_upper   <= (i_req.kind == KIND_HEX_UPPER);
                    r_w       <= w_in;
                    r_right   <= i_req.left_align;
                    r_zero    <= i_req.zero_fill;
                    r_bit_cnt <= 5'd0;
                    r_nd      <= 4'(NUM_DIGITS);
                    r_dig     <= req_hex ? DIG_BITS'(i_req.value) : '0;
                end
            end
            S_CONV: begin
                // One magnitude bit enters the BCD register per cycle, most significant first.
                r_dig     <= {dig_adj[DIG_BITS-2:0], r_bin[BIN_W-1]};
                r_bin     <= {r_bin[BIN_W-2:0], 1'b0};
                r_bit_cnt <= r_bit_cnt + 5'd1;
            end
            S_NORM: begin
                if (norm_shift) begin
                    r_dig <= {r_dig[DIG_BITS-5:0], 4'd0};
                    r_nd  <= r_nd - 4'd1;
                end
            end
            S_PREP: begin
                r_pad_cnt <= padn;
                r_sign    <= sign_mid;
            end
            S_LPAD, S_RPAD: begin
                if (emit) begin
                    r_pad_cnt <= r_pad_cnt - 5'd1;
                end
            end
            S_DIGIT: begin
                if (emit) begin
                    r_dig <= {r_dig[DIG_BITS-5:0], 4'd0};
                    r_nd  <= r_nd - 4'd1;
                end
            end
            default: begin
                r_nd <= r_nd;
            end
        endcase
        if (emit) begin
            r_out_char <= emit_char;
            r_out_last <= emit_last;
        end
    end

endmodule

FILE: hw/rtl/itoa_checker.sv
// Port-level checks of the padded integer-to-ASCII formatter, bound to its top level.
`include "assert_macros.svh"

module itoa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_chr_valid,
    input logic       i_chr_ready,
    input logic [7:0] i_chr_code,
    input logic       i_chr_last
);

    // A character waiting at the output holds until it is taken.
    `ASSERT_NEXT(a_chr_hold, i_clk, i_rst_n, i_chr_valid && !i_chr_ready, i_chr_valid && $stable(i_chr_code) && $stable(i_chr_last))

    // Once a request is taken, no further request is taken in the next cycle.
    `ASSERT_NEXT(a_req_busy, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // A number that is still incomplete keeps the request side closed.
    `ASSERT_NOW(a_mid_number, i_clk, i_rst_n, i_chr_valid && !i_chr_last, !i_req_ready)

    // Only space, minus, decimal digits and hex letters are ever produced.
    `ASSERT_NOW(a_char_range, i_clk, i_rst_n, i_chr_valid, (i_chr_code == 8'h20) || (i_chr_code == 8'h2D) || ((i_chr_code >= 8'h30) && (i_chr_code <= 8'h39)) || ((i_chr_code >= 8'h41) && (i_chr_code <= 8'h46)) || ((i_chr_code >= 8'h61) && (i_chr_code <= 8'h66)))

endmodule

bind integer_to_ascii_padded_core itoa_checker u_itoa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_chr_valid (o_chr.valid),
    .i_chr_ready (o_chr.ready),
    .i_chr_code  (o_chr.char_code),
    .i_chr_last  (o_chr.last)
);

FILE: test/itoa_text_checker.sv
// Watches both channels of the formatter, predicts each number's text and compares it.
module itoa_text_checker
    import itoa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    itoa_req_if  i_req,
    itoa_chr_if  i_chr,
    output int   o_errors,
    output int   o_pending
);

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_char_item;

    t_char_item expected_chars[$];
    int         error_count = 0;

    // Builds the text of one request and queues its characters in order.
    function automatic void queue_number_text(input logic [31:0] value, input logic [1:0] kind,
                                              input logic [4:0] width, input logic left_align,
                                              input logic zero_fill);
        logic [7:0]  digits_rev[0:11];
        logic [7:0]  body[0:11];
        logic [7:0]  text_out[0:31];
        logic [31:0] mag;
        logic [3:0]  d;
        logic [7:0]  fill;
        logic [7:0]  letter_base;
        logic        neg;
        int unsigned base;
        int          nd;
        int          bl;
        int          n;
        int          w;
        int          pad_count;
        t_char_item  item;
        nd          = 0;
        bl          = 0;
        n           = 0;
        w           = int'(width);
        neg         = (kind == KIND_SDEC) && value[31];
        mag         = neg ? (32'd0 - value) : value;
        base        = (kind == KIND_HEX_LOWER || kind == KIND_HEX_UPPER) ? 16 : 10;
        letter_base = (kind == KIND_HEX_UPPER) ? CH_UA : CH_LA;
        fill        = zero_fill ? CH_ZERO : CH_SPACE;
        if (w > int'(MAX_FIELD_WIDTH)) begin
            w = int'(MAX_FIELD_WIDTH);
        end
        do begin
            d = 4'(mag % base);
            digits_rev[nd] = (d < 4'd10) ? (CH_ZERO + 8'(d)) : (letter_base + 8'(d) - 8'd10);
            nd++;
            mag = mag / base;
        end while (mag != 32'd0);
        // With zero padding and a width, the sign leads the field and uses up one place of it.
        if (neg) begin
            if (w != 0 && zero_fill) begin
                text_out[n] = CH_MINUS;
                n++;
                w--;
            end else begin
                body[bl] = CH_MINUS;
                bl++;
            end
        end
        for (int i = nd - 1; i >= 0; i--) begin
            body[bl] = digits_rev[i];
            bl++;
        end
        pad_count = (w > bl) ? (w - bl) : 0;
        if (!left_align) begin
            for (int i = 0; i < pad_count; i++) begin
                text_out[n] = fill;
                n++;
            end
        end
        for (int i = 0; i < bl; i++) begin
            text_out[n] = body[i];
            n++;
        end
        if (left_align) begin
            for (int i = 0; i < pad_count; i++) begin
                text_out[n] = fill;
                n++;
            end
        end
        for (int i = 0; i < n; i++) begin
            item.char_code = text_out[i];
            item.last      = (i == n - 1);
            expected_chars.push_back(item);
        end
    endfunction

    always @(posedge i_clk) begin
        t_char_item want;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready) begin
                queue_number_text(i_req.value, i_req.kind, i_req.field_width,
                                  i_req.left_align, i_req.zero_fill);
            end
            if (i_chr.valid && i_chr.ready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected character: expected none, actual code %h last %b",
                             $time, i_chr.char_code, i_chr.last);
                    error_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (i_chr.char_code !== want.char_code) begin
                        $display("%0t: char_code mismatch: expected %h, actual %h",
                                 $time, want.char_code, i_chr.char_code);
                        error_count++;
                    end
                    if (i_chr.last !== want.last) begin
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, want.last, i_chr.last);
                        error_count++;
                    end
                end
            end
        end
        o_errors  <= error_count;
        o_pending <= expected_chars.size();
    end

endmodule

FILE: test/testbench.sv
// Top of the formatter test: clock, reset, request stimulus, character back-pressure and verdict.
module testbench;
    import itoa_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycle_count = 0;
    int   errors;
    int   pending;
    logic calm;

    itoa_req_if req_ch ();
    itoa_chr_if chr_ch ();

    integer_to_ascii_padded_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_chr   (chr_ch)
    );

    itoa_text_checker text_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .i_chr     (chr_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Neither side idles inside this window of cycles.
    assign calm = (cycle_count >= 6000) && (cycle_count < 12000);

    always @(posedge i_clk) begin
        cycle_count  <= cycle_count + 1;
        chr_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 13);
    end

    // Presents one request, with a random gap before it, and holds it until it is taken.
    task automatic issue_request(input logic [31:0] value, input logic [1:0] kind,
                                 input logic [4:0] width, input logic left_align,
                                 input logic zero_fill);
        while (!calm && $urandom_range(0, 99) < 13) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.value       <= value;
        req_ch.kind        <= kind;
        req_ch.field_width <= width;
        req_ch.left_align  <= left_align;
        req_ch.zero_fill   <= zero_fill;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        logic [31:0] value;
        logic [1:0]  kind;
        logic [4:0]  width;
        logic [31:0] specials[0:7];
        int          mode;
        specials = '{32'h0, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'hFFFF_FFFF, 32'd10, 32'd9, 32'hF};
        req_ch.valid       = 1'b0;
        req_ch.value       = '0;
        req_ch.kind        = KIND_SDEC;
        req_ch.field_width = '0;
        req_ch.left_align  = 1'b0;
        req_ch.zero_fill   = 1'b0;
        i_rst_n            = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero and all-ones in every kind, then the sign and padding corner cases.
        issue_request(32'h0, KIND_SDEC, 5'd0, 1'b0, 1'b0);
        issue_request(32'h0, KIND_UDEC, 5'd3, 1'b0, 1'b1);
        issue_request(32'h0, KIND_HEX_LOWER, 5'd2, 1'b1, 1'b0);
        issue_request(32'h0, KIND_HEX_UPPER, 5'd31, 1'b1, 1'b1);
        issue_request(32'hFFFF_FFFF, KIND_SDEC, 5'd0, 1'b0, 1'b0);
        issue_request(32'hFFFF_FFFF, KIND_UDEC, 5'd0, 1'b0, 1'b0);
        issue_request(32'hFFFF_FFFF, KIND_HEX_LOWER, 5'd0, 1'b0, 1'b0);
        issue_request(32'hFFFF_FFFF, KIND_HEX_UPPER, 5'd31, 1'b0, 1'b1);
        issue_request(32'h8000_0000, KIND_SDEC, 5'd0, 1'b0, 1'b0);
        issue_request(32'h8000_0000, KIND_SDEC, 5'd31, 1'b0, 1'b1);
        issue_request(32'h7FFF_FFFF, KIND_SDEC, 5'd31, 1'b1, 1'b0);
        issue_request(-32'sd5, KIND_SDEC, 5'd4, 1'b1, 1'b1);
        issue_request(-32'sd5, KIND_SDEC, 5'd4, 1'b0, 1'b1);
        issue_request(-32'sd5, KIND_SDEC, 5'd4, 1'b0, 1'b0);
        issue_request(-32'sd5, KIND_SDEC, 5'd4, 1'b1, 1'b0);
        issue_request(-32'sd5, KIND_SDEC, 5'd1, 1'b0, 1'b1);
        issue_request(-32'sd5, KIND_SDEC, 5'd0, 1'b0, 1'b1);
        issue_request(-32'sd5, KIND_UDEC, 5'd0, 1'b0, 1'b0);
        issue_request(32'd123456, KIND_UDEC, 5'd3, 1'b0, 1'b1);
        issue_request(32'hDEAD_BEEF, KIND_HEX_UPPER, 5'd8, 1'b0, 1'b1);
        issue_request(32'hABCD_EF01, KIND_HEX_LOWER, 5'd31, 1'b1, 1'b0);
        issue_request(32'd42, KIND_UDEC, 5'd31, 1'b0, 1'b0);

        for (int n = 0; n < 360; n++) begin
            mode  = $urandom_range(0, 9);
            kind  = 2'($urandom_range(0, 3));
            value = $urandom();
            case (mode)
                4: begin
                    value = $urandom_range(0, 20);
                end
                5: begin
                    value = 32'd0 - 32'($urandom_range(1, 20));
                    if ($urandom_range(0, 1) == 0) begin
                        kind = KIND_SDEC;
                    end
                end
                6: begin
                    value = specials[$urandom_range(0, 7)];
                end
                7: begin
                    value = $urandom_range(0, 999999);
                end
                8: begin
                    value = $urandom() >> $urandom_range(0, 31);
                end
                default: begin
                end
            endcase
            case ($urandom_range(0, 3))
                0:       width = 5'd0;
                1:       width = 5'($urandom_range(1, 6));
                default: width = 5'($urandom_range(0, 31));
            endcase
            issue_request(value, kind, width, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
        end
        req_ch.valid <= 1'b0;

        // The checker's pending count is registered and lags the accepting edge.
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (80) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(12 * 600000);
        $display("FAIL");
        $finish;
    end

endmodule
